FILE: rtl/sfe_pkg.sv
// ---------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants of the setpoint frame encoder.
// ---------------------------------------------------------------------------
package sfe_pkg;

    localparam int unsigned CHANNELS   = 6;
    localparam int unsigned SP_WIDTH   = 32;
    localparam int unsigned SP_BYTES   = SP_WIDTH / 8;
    localparam int unsigned CH_W       = 3;
    localparam logic [7:0]  FRAME_MARK = 8'h7E;

    typedef logic [SP_WIDTH-1:0] t_setpoint;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_BODY,
        PH_CHECK,
        PH_FOOT
    } t_phase;

endpackage

FILE: rtl/setpoint_frame_encoder_top.sv
// ---------------------------------------------------------------------------
// setpoint_frame_encoder_top
// Serializes six setpoints into one framed byte stream with XOR check.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one word of six 32-bit setpoints (setpoint_0 in the
//   lowest bits). m_axis returns the frame one byte per word: 0x7E header,
//   per channel an address byte (1..6) and SETPOINT_BYTES data bytes, least
//   significant first, the XOR check byte and a 0x7E footer marked by tlast.
//   A frame is 6 * (SETPOINT_BYTES + 1) + 3 words, 33 at the default size.
//   Throughput: the single byte sequencer walks the frame one byte per
//   cycle while the output is not stalled, one frame at a time.
//   An accepted word sets the header state, which then registers the header.
//   The next input word is taken in the cycle the footer is generated, so
//   frames follow without gaps.
//   Stall: while m_axis_tready is low the output register holds and the
//   sequencer waits; s_axis_tready stays low until the current frame's
//   footer has been generated.
//   Reset: i_rst_n (synchronous, active low) drops any frame in progress
//   and clears the output valid.
// ---------------------------------------------------------------------------
module setpoint_frame_encoder_top #(
    parameter int unsigned SETPOINT_BYTES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // setpoint_0 .. setpoint_5, 32 bits each
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // frame_byte
    output logic         m_axis_tlast   // frame_end
);
    import sfe_pkg::*;

    localparam int unsigned K_W        = $clog2(SETPOINT_BYTES + 1);
    localparam int unsigned SENT_BYTES = (SETPOINT_BYTES < SP_BYTES) ?
                                         SETPOINT_BYTES : SP_BYTES;

    t_setpoint            r_sp [CHANNELS];
    logic [7:0]           r_check;
    t_phase               r_state, n_state;
    logic [CH_W-1:0]      r_ch, n_ch;
    logic [K_W-1:0]       r_k, n_k;
    logic                 r_ovalid;
    logic [7:0]           r_obyte;
    logic                 r_olast;

    logic                 advance;
    logic                 accept;
    logic [7:0]           in_check;
    logic [7:0]           gen_byte;
    logic                 gen_last;
    t_setpoint            sel_sp;

    assign advance = (r_state != PH_IDLE) && (!r_ovalid || m_axis_tready);
    assign accept  = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_check = 8'h00;
        for (int c = 0; c < CHANNELS; c++) begin
            in_check = in_check ^ 8'(c + 1);
            for (int k = 0; k < SENT_BYTES; k++) begin
                in_check = in_check ^ s_axis_tdata[c*SP_WIDTH + 8*k +: 8];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_k     = r_k;
        if (advance) begin
            unique case (r_state)
                PH_HEAD: begin
                    n_state = PH_BODY;
                    n_ch    = '0;
                    n_k     = '0;
                end
                PH_BODY: begin
                    if (r_k == K_W'(SETPOINT_BYTES)) begin
                        n_k = '0;
                        if (r_ch == CH_W'(CHANNELS - 1)) begin
                            n_state = PH_CHECK;
                        end else begin
                            n_ch = r_ch + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
                PH_CHECK: n_state = PH_FOOT;
                PH_FOOT:  n_state = PH_IDLE;
                default:  n_state = PH_IDLE;
            endcase
        end
        if (accept) begin
            n_state = PH_HEAD;
        end
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == PH_IDLE) || (advance && (r_state == PH_FOOT));
        sel_sp   = r_sp[r_ch];
        gen_byte = 8'h00;
        gen_last = 1'b0;
        unique case (r_state)
            PH_HEAD:  gen_byte = FRAME_MARK;
            PH_BODY: begin
                if (r_k == '0) begin
                    gen_byte = 8'(r_ch) + 8'd1;
                end else begin
                    for (int k = 0; k < SENT_BYTES; k++) begin
                        if (r_k == K_W'(k + 1)) begin
                            gen_byte = sel_sp[8*k +: 8];
                        end
                    end
                end
            end
            PH_CHECK: gen_byte = r_check;
            PH_FOOT: begin
                gen_byte = FRAME_MARK;
                gen_last = 1'b1;
            end
            default:  gen_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PH_IDLE;
            r_ch     <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_k     <= n_k;
            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sp[c] <= s_axis_tdata[c*SP_WIDTH +: SP_WIDTH];
            end
            r_check <= in_check;
        end
        if (advance) begin
            r_obyte <= gen_byte;
            r_olast <= gen_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;

    a_last_is_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == FRAME_MARK))
        else $error("frame end word is not the footer mark");

    a_accept_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ((r_state == PH_IDLE) || (r_state == PH_FOOT)))
        else $error("input word taken in the middle of a frame");

    a_body_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PH_BODY) |->
            ((r_ch < CH_W'(CHANNELS)) && (r_k <= K_W'(SETPOINT_BYTES))))
        else $error("body counters out of range");

    a_head_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == PH_HEAD))
        else $error("frame did not start after input word");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the setpoint frame encoder.
// ---------------------------------------------------------------------------
// Six-setpoint words go in on s_axis. A built-in frame builder queues the
// bytes that each accepted word must produce: header, address and data bytes
// least significant first, XOR check, and the footer flagged by tlast. Every
// byte taken from m_axis is checked against the oldest queued byte. A short
// directed table comes first. It is followed by random words, sent under
// random gaps, random stalls, bursts with no idling, and a long output hold.
// ---------------------------------------------------------------------------
module tb;
    import sfe_pkg::*;

    localparam int unsigned FRAME_BYTES    = 4;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 40;

    typedef struct {
        logic [191:0] word;       // setpoint_0 in the lowest bits
        logic         chk_known;
        logic [7:0]   chk;
    } t_vector;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata  = '0;   // setpoint_0 .. setpoint_5, 32 bits each
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;         // frame_byte
    logic         m_axis_tlast;         // frame_end

    t_frame_word frame_bytes_due[$];
    int          mismatch_count  = 0;
    int          bytes_seen      = 0;
    int          frames_seen     = 0;
    int          words_sent      = 0;
    int          idle_cycles     = 0;
    bit          sender_idle_on  = 1'b1;
    bit          receiver_idle_on = 1'b1;
    bit          hold_request    = 1'b0;

    t_vector directed_table[12] = '{
        '{{6{32'h0000_0000}}, 1'b1, 8'h07},
        '{{6{32'hFFFF_FFFF}}, 1'b1, 8'h07},
        '{{6{32'h7E7E_7E7E}}, 1'b1, 8'h07},
        '{{{5{32'h0000_0000}}, 32'h0000_0079}, 1'b1, 8'h7E},
        '{{{5{32'h0000_0000}}, 32'h0000_0001}, 1'b1, 8'h06},
        '{{32'h8000_0000, {5{32'h0000_0000}}}, 1'b1, 8'h87},
        '{{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98,
           32'h7654_3210, 32'hDEAD_BEEF, 32'hCAFE_F00D}, 1'b0, 8'h00},
        '{{32'h0000_0020, 32'h0000_0010, 32'h0000_0008,
           32'h0000_0004, 32'h0000_0002, 32'h0000_0001}, 1'b0, 8'h00},
        '{{3{32'h7FFF_FFFF, 32'h8000_0000}}, 1'b0, 8'h00},
        '{{32'h3F80_0000, 32'hBF80_0000, 32'h4049_0FDB,
           32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000}, 1'b0, 8'h00},
        '{{3{32'h5555_5555, 32'hAAAA_AAAA}}, 1'b0, 8'h00},
        '{{32'h7E00_007E, 32'h007E_7E00, 32'h1234_567E,
           32'h7E56_3412, 32'h0000_7E00, 32'h7E7E_0000}, 1'b0, 8'h00}
    };

    setpoint_frame_encoder_top #(
        .SETPOINT_BYTES(FRAME_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic void push_frame_word(input logic [7:0] data, input logic last);
        t_frame_word fw;
        fw.data = data;
        fw.last = last;
        frame_bytes_due.push_back(fw);
    endfunction

    // build the frame that one setpoint word must produce
    function automatic void queue_frame(input logic [191:0] word, input logic chk_known,
                                        input logic [7:0] chk);
        logic [7:0] xor_sum;
        t_setpoint  sp;
        logic [7:0] data;
        xor_sum = 8'h00;
        push_frame_word(FRAME_MARK, 1'b0);
        for (int c = 0; c < CHANNELS; c++) begin
            sp = word[c*32 +: 32];
            push_frame_word(8'(c + 1), 1'b0);
            xor_sum ^= 8'(c + 1);
            for (int k = 0; k < FRAME_BYTES; k++) begin
                data = (k < SP_BYTES) ? sp[k*8 +: 8] : 8'h00;
                push_frame_word(data, 1'b0);
                xor_sum ^= data;
            end
        end
        push_frame_word(chk_known ? chk : xor_sum, 1'b0);
        push_frame_word(FRAME_MARK, 1'b1);
    endfunction

    function automatic t_setpoint draw_setpoint();
        t_setpoint sp;
        case ($urandom_range(0, 5))
            0: sp = 32'h0000_0000;
            1: sp = 32'hFFFF_FFFF;
            2: sp = {4{8'h7E}};
            3: sp = 32'h1 << $urandom_range(0, 31);
            default: sp = $urandom;
        endcase
        return sp;
    endfunction

    function automatic logic [191:0] draw_word();
        logic [191:0] word;
        for (int c = 0; c < CHANNELS; c++) begin
            word[c*32 +: 32] = draw_setpoint();
        end
        return word;
    endfunction

    task automatic send_word(input logic [191:0] word, input logic chk_known,
                             input logic [7:0] chk);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_frame(word, chk_known, chk);
        words_sent++;
    endtask

    task automatic stop_and_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (frame_bytes_due.size() == 0);
    endtask

    // receiver: random stalls per word, long hold on request
    initial begin
        int          stall;
        t_frame_word fw;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = receiver_idle_on ? $urandom_range(0, 7) : 0;
            if (hold_request) begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            bytes_seen++;
            if (m_axis_tlast) frames_seen++;
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected frame word: frame_byte=%h frame_end=%b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                fw = frame_bytes_due.pop_front();
                if (m_axis_tdata !== fw.data) begin
                    $error("frame_byte: expected %h, actual %h", fw.data, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== fw.last) begin
                    $error("frame_end: expected %b, actual %b", fw.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_table[i]) begin
            send_word(directed_table[i].word, directed_table[i].chk_known,
                      directed_table[i].chk);
        end
        stop_and_drain();

        // back-to-back frames with no idling on either side
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int i = 0; i < 60; i++) send_word(draw_word(), 1'b0, 8'h00);
        stop_and_drain();

        // hold the output long enough to back up the input
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) send_word(draw_word(), 1'b0, 8'h00);
        stop_and_drain();

        for (int i = 0; i < 185; i++) begin
            if (i % 25 == 0) begin
                sender_idle_on   = $urandom_range(0, 3) != 0;
                receiver_idle_on = $urandom_range(0, 3) != 0;
            end
            send_word(draw_word(), 1'b0, 8'h00);
        end
        stop_and_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d setpoint words (%0d directed), %0d frames, %0d bytes",
                 words_sent, $size(directed_table), frames_seen, bytes_seen);
        $display("with random gaps, stalls, idle-free bursts and a %0d-cycle output hold",
                 LONG_HOLD);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
